/* hdl/abf_pkg.sv */
package abf_pkg;

    localparam int LUX_FIELD_W  = 16;
    localparam int LUX_BITS_DEF = 16;
    localparam int PCT_W        = 7;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_VAL_W    = 16;

    localparam logic [PCT_W-1:0]        FULL_PERCENT   = 7'd100;
    localparam logic [PCT_W-1:0]        TARGET_RESET   = 7'd100;
    localparam logic [LUX_FIELD_W-1:0]  LUX_LO_RESET   = 16'd0;
    localparam logic [LUX_FIELD_W-1:0]  LUX_HI_RESET   = 16'd1000;
    localparam logic [PCT_W-1:0]        LEVEL_RESET    = 7'd100;

    localparam int MAP_SCALE = 200;
    localparam int STEP_BIAS = 9;
    localparam int RECIP_MUL = 205;
    localparam int RECIP_SHR = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 4'd0,
        REG_TARGET = 4'd1,
        REG_LUX_LO = 4'd2,
        REG_LUX_HI = 4'd3
    } cfg_index_t;

    typedef struct packed {
        logic                    manual_mode;
        logic [PCT_W-1:0]        manual_target;
        logic [LUX_FIELD_W-1:0]  lux_low_bound;
        logic [LUX_FIELD_W-1:0]  lux_high_bound;
    } cfg_t;

    function automatic logic [PCT_W-1:0] sat_target(input logic [PCT_W-1:0] t);
        logic [PCT_W-1:0] r;
        r = (t > FULL_PERCENT) ? FULL_PERCENT : t;
        return r;
    endfunction

    function automatic logic [PCT_W-1:0] fade_next(input logic [PCT_W-1:0] cur,
                                                    input logic [PCT_W-1:0] tgt);
        logic [PCT_W-1:0] delta;
        logic [PCT_W:0]   biased;
        logic [15:0]      prod;
        logic [PCT_W-1:0] step;
        logic [PCT_W:0]   sum;
        logic [PCT_W-1:0] r;
        delta  = (cur > tgt) ? (cur - tgt) : (tgt - cur);
        biased = {1'b0, delta} + (PCT_W+1)'(STEP_BIAS);
        prod   = 16'(biased) * 16'(RECIP_MUL);
        step   = PCT_W'(prod >> RECIP_SHR);
        sum    = {1'b0, cur} + {1'b0, step};
        if (cur == tgt)
        begin
            r = cur;
        end
        else if (cur < tgt)
        begin
            r = (sum > {1'b0, tgt}) ? tgt : sum[PCT_W-1:0];
        end
        else
        begin
            r = (step > delta) ? tgt : (cur - step);
        end
        return r;
    endfunction

endpackage

/* hdl/abf_if.sv */
interface abf_lux_if;
    logic                              valid;
    logic                              ready;
    logic [abf_pkg::LUX_FIELD_W-1:0]   lux_sample;

    modport source (output valid, output lux_sample, input ready);
    modport sink   (input valid, input lux_sample, output ready);
endinterface

interface abf_level_if;
    logic                          valid;
    logic                          ready;
    logic [abf_pkg::PCT_W-1:0]     applied_percent;

    modport source (output valid, output applied_percent, input ready);
    modport sink   (input valid, input applied_percent, output ready);
endinterface

interface abf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [abf_pkg::CFG_IDX_W-1:0]     index;
    logic [abf_pkg::CFG_VAL_W-1:0]     value;

    modport source (output valid, output index, output value, input ready);
    modport sink   (input valid, input index, input value, output ready);
endinterface

/* hdl/abf_cfg_regs.sv */
module abf_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    abf_cfg_if.sink        cfg,
    output abf_pkg::cfg_t  regs
);

    abf_pkg::cfg_t cfg_reg;
    abf_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                abf_pkg::REG_MODE:   cfg_next.manual_mode    = cfg.value[0];
                abf_pkg::REG_TARGET: cfg_next.manual_target  = cfg.value[abf_pkg::PCT_W-1:0];
                abf_pkg::REG_LUX_LO: cfg_next.lux_low_bound  =
                                         cfg.value[abf_pkg::LUX_FIELD_W-1:0];
                abf_pkg::REG_LUX_HI: cfg_next.lux_high_bound =
                                         cfg.value[abf_pkg::LUX_FIELD_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.manual_mode    <= 1'b0;
            cfg_reg.manual_target  <= abf_pkg::TARGET_RESET;
            cfg_reg.lux_low_bound  <= abf_pkg::LUX_LO_RESET;
            cfg_reg.lux_high_bound <= abf_pkg::LUX_HI_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/abf_div.sv */
module abf_div #(
    parameter int LUX_W = abf_pkg::LUX_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [LUX_W+7:0]            num,
    input  logic [LUX_W-1:0]            span,
    output logic                        done,
    output logic [abf_pkg::PCT_W-1:0]   quot
);

    localparam int NW    = LUX_W + 8;
    localparam int QW    = abf_pkg::PCT_W;
    localparam int CNT_W = $clog2(QW);

    logic [NW-1:0]    rem_reg;
    logic [NW-1:0]    dvs_reg;
    logic [QW-1:0]    quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             take;

    assign take = (rem_reg >= dvs_reg);
    assign done = done_reg;
    assign quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            dvs_reg  <= NW'(span) << QW;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            dvs_reg  <= dvs_reg >> 1;
            quot_reg <= {quot_reg[QW-2:0], take};
        end
    end

endmodule

/* hdl/ambient_brightness_fader_unit.sv */
// Channel   Dir  Payload                  Handshake
// lux       in   lux_sample [15:0]        valid / ready
// level     out  applied_percent [6:0]    valid / ready
// cfg       in   index [3:0], value [15:0] valid / ready (always ready)
//
// Auto mode steps: accept, clamp, difference, scale, 7-step serial divide, fade.
// Empty lux range: accept, clamp, difference, fade (no divide). Manual mode: accept, fade.
// The serial divider is the longest step of auto mode.
// Reset sets the applied level to 100 and the registers to their reset values.
// A pending result waits in the output register; the next item is taken meanwhile,
// and its fade step holds until the output register is free.
module ambient_brightness_fader_unit #(
    parameter int LUX_BITS = abf_pkg::LUX_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    abf_lux_if.sink      lux,
    abf_level_if.source  level,
    abf_cfg_if.sink      cfg
);

    localparam int LUX_W = (LUX_BITS < abf_pkg::LUX_FIELD_W) ? LUX_BITS
                                                             : abf_pkg::LUX_FIELD_W;
    localparam int NW    = LUX_W + 8;
    localparam int PW    = abf_pkg::PCT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLAMP = 6'b000010,
        S_DIFF  = 6'b000100,
        S_MUL   = 6'b001000,
        S_DIV   = 6'b010000,
        S_FADE  = 6'b100000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    abf_pkg::cfg_t     regs;
    logic [LUX_W-1:0]  lo;
    logic [LUX_W-1:0]  hi;
    logic [LUX_W-1:0]  lux_reg;
    logic [LUX_W-1:0]  span_reg;
    logic              empty_reg;
    logic [PW-1:0]     desired_reg;
    logic [PW-1:0]     level_reg;
    logic              out_valid_reg;
    logic [NW-1:0]     num;
    logic              div_start;
    logic              div_done;
    logic [PW-1:0]     div_quot;
    logic              out_free;

    abf_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    abf_div #(
        .LUX_W (LUX_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .span  (span_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign lo        = regs.lux_low_bound[LUX_W-1:0];
    assign hi        = regs.lux_high_bound[LUX_W-1:0];
    assign num       = NW'(lux_reg) * NW'(abf_pkg::MAP_SCALE) + NW'(span_reg);
    assign div_start = (state_reg == S_MUL);
    assign out_free  = !out_valid_reg || level.ready;

    assign lux.ready             = (state_reg == S_IDLE);
    assign level.valid           = out_valid_reg;
    assign level.applied_percent = level_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (lux.valid)
                begin
                    state_next = regs.manual_mode ? S_FADE : S_CLAMP;
                end
            end
            S_CLAMP: state_next = S_DIFF;
            S_DIFF:  state_next = empty_reg ? S_FADE : S_MUL;
            S_MUL:   state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FADE;
                end
            end
            S_FADE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= abf_pkg::LEVEL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FADE && out_free)
            begin
                level_reg     <= abf_pkg::fade_next(level_reg, desired_reg);
                out_valid_reg <= 1'b1;
            end
            else if (level.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                lux_reg     <= lux.lux_sample[LUX_W-1:0];
                desired_reg <= abf_pkg::sat_target(regs.manual_target);
            end
            S_CLAMP:
            begin
                empty_reg <= (hi <= lo);
                if (lux_reg < lo)
                begin
                    lux_reg <= lo;
                end
                else if (lux_reg > hi)
                begin
                    lux_reg <= hi;
                end
            end
            S_DIFF:
            begin
                span_reg    <= hi - lo;
                lux_reg     <= lux_reg - lo;
                desired_reg <= abf_pkg::FULL_PERCENT;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    desired_reg <= abf_pkg::FULL_PERCENT - div_quot;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import abf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;
    localparam int NUM_PHASES   = 16;
    localparam int PHASE_ITEMS  = 34;
    localparam int HOLD_PHASE   = 5;
    localparam int PAUSE_PHASE  = 3;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    typedef enum bit {ROW_LUX, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [15:0]           data;
        bit                    has_lit;
        logic [PCT_W-1:0]      lit_pct;
    } dir_row_t;

    logic clk;
    logic rst_n;

    abf_lux_if   lux_ch ();
    abf_level_if lvl_ch ();
    abf_cfg_if   cfg_ch ();

    ambient_brightness_fader_unit #(
        .LUX_BITS (LUX_BITS_DEF)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .lux   (lux_ch),
        .level (lvl_ch),
        .cfg   (cfg_ch)
    );

    logic                   pred_mode;
    logic [PCT_W-1:0]       pred_target;
    logic [15:0]            pred_lo;
    logic [15:0]            pred_hi;
    logic [PCT_W-1:0]       pred_level;
    logic [PCT_W-1:0]       expected_levels [$];

    dir_row_t dir_rows [29];

    int err_cnt         = 0;
    int items_sent      = 0;
    int regs_written    = 0;
    int results_checked = 0;
    int hold_req        = 0;
    bit idle_on         = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [PCT_W-1:0] map_lux_pct(input logic [15:0] lux,
                                                     input logic [15:0] lo,
                                                     input logic [15:0] hi);
        logic [31:0] span;
        logic [31:0] offs;
        logic [31:0] pct;
        logic [15:0] c;
        if (hi <= lo)
        begin
            return '0;
        end
        c = lux;
        if (c < lo)
        begin
            c = lo;
        end
        if (c > hi)
        begin
            c = hi;
        end
        span = 32'(hi) - 32'(lo);
        offs = 32'(c) - 32'(lo);
        pct  = (offs * MAP_SCALE + span) / (span * 2);
        if (pct > 32'(FULL_PERCENT))
        begin
            pct = 32'(FULL_PERCENT);
        end
        return pct[PCT_W-1:0];
    endfunction

    function automatic logic [PCT_W-1:0] fade_toward(input logic [PCT_W-1:0] cur,
                                                     input logic [PCT_W-1:0] tgt);
        int c;
        int t;
        int d;
        int s;
        c = cur;
        t = tgt;
        if (c == t)
        begin
            return cur;
        end
        d = (c > t) ? c - t : t - c;
        s = (d + STEP_BIAS) / 10;
        if (s < 1)
        begin
            s = 1;
        end
        if (c < t)
        begin
            return (c + s > t) ? tgt : PCT_W'(c + s);
        end
        return (s > d) ? tgt : PCT_W'(c - s);
    endfunction

    function automatic logic [PCT_W-1:0] predict_level(input logic [15:0] lux);
        logic [PCT_W-1:0] goal;
        if (pred_mode)
        begin
            goal = (pred_target > FULL_PERCENT) ? FULL_PERCENT : pred_target;
        end
        else
        begin
            goal = FULL_PERCENT - map_lux_pct(lux, pred_lo, pred_hi);
        end
        return fade_toward(pred_level, goal);
    endfunction

    task automatic send_lux(input logic [15:0] lux, input bit has_lit = 1'b0,
                            input logic [PCT_W-1:0] lit = '0);
        logic [PCT_W-1:0] nxt;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            lux_ch.valid      <= 1'b0;
            lux_ch.lux_sample <= 16'($urandom());
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        lux_ch.valid      <= 1'b1;
        lux_ch.lux_sample <= lux;
        @(posedge clk);
        while (!lux_ch.ready)
        begin
            @(posedge clk);
        end
        nxt        = predict_level(lux);
        pred_level = nxt;
        expected_levels.push_back(has_lit ? lit : nxt);
        items_sent++;
    endtask

    task automatic drain_results();
        lux_ch.valid <= 1'b0;
        wait (expected_levels.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.value <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_MODE:   pred_mode   = data[0];
            REG_TARGET: pred_target = data[PCT_W-1:0];
            REG_LUX_LO: pred_lo     = data;
            REG_LUX_HI: pred_hi     = data;
            default:    ;
        endcase
        regs_written++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int stall_left;
        int hold_left;
        int hold_seen;
        logic [PCT_W-1:0] want;
        stall_left = 0;
        hold_left  = 0;
        hold_seen  = 0;
        lvl_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && lvl_ch.valid && lvl_ch.ready)
            begin
                results_checked++;
                if (expected_levels.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                    begin
                        $display("unexpected item: applied_percent=%0d",
                                 lvl_ch.applied_percent);
                    end
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (lvl_ch.applied_percent !== want)
                    begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                        begin
                            $display("mismatch on item %0d: expected %0d, got %0d",
                                     results_checked, want, lvl_ch.applied_percent);
                        end
                    end
                end
            end
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                lvl_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                lvl_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                lvl_ch.ready <= 1'b0;
            end
            else
            begin
                lvl_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [15:0]      lo_v;
        logic [15:0]      hi_v;
        logic [15:0]      lo_s;
        logic [15:0]      hi_s;
        logic [15:0]      lux_v;
        logic [15:0]      t16;
        logic [PCT_W-1:0] t7;

        rst_n             <= 1'b0;
        lux_ch.valid      <= 1'b0;
        lux_ch.lux_sample <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= '0;
        cfg_ch.value      <= '0;

        pred_mode   = 1'b0;
        pred_target = TARGET_RESET;
        pred_lo     = LUX_LO_RESET;
        pred_hi     = LUX_HI_RESET;
        pred_level  = LEVEL_RESET;

        dir_rows = '{
            '{ROW_LUX, REG_MODE,     16'd0,     1'b1, 7'd100},
            '{ROW_LUX, REG_MODE,     16'hFFFF,  1'b1, 7'd90},
            '{ROW_LUX, REG_MODE,     16'd1000,  1'b1, 7'd81},
            '{ROW_LUX, REG_MODE,     16'd500,   1'b0, 7'd0},
            '{ROW_LUX, REG_MODE,     16'd5,     1'b0, 7'd0},
            '{ROW_REG, REG_MODE,     16'd1,     1'b0, 7'd0},
            '{ROW_REG, REG_TARGET,   16'd0,     1'b0, 7'd0},
            '{ROW_LUX, REG_MODE,     16'd0,     1'b0, 7'd0},
            '{ROW_LUX, REG_MODE,     16'hFFFF,  1'b0, 7'd0},
            '{ROW_REG, REG_TARGET,   16'd127,   1'b0, 7'd0},
            '{ROW_LUX, REG_MODE,     16'h1234,  1'b0, 7'd0},
            '{ROW_REG, REG_TARGET,   16'd101,   1'b0, 7'd0},
            '{ROW_LUX, REG_MODE,     16'hA5A5,  1'b0, 7'd0},
            '{ROW_REG, REG_MODE,     16'd0,     1'b0, 7'd0},
            '{ROW_REG, REG_LUX_LO,   16'd500,   1'b0, 7'd0},
            '{ROW_REG, REG_LUX_HI,   16'd500,   1'b0, 7'd0},
            '{ROW_LUX, REG_MODE,     16'd700,   1'b0, 7'd0},
            '{ROW_REG, REG_LUX_LO,   16'hFFFF,  1'b0, 7'd0},
            '{ROW_REG, REG_LUX_HI,   16'd0,     1'b0, 7'd0},
            '{ROW_REG, REG_SPARE_LO, 16'hFFFF,  1'b0, 7'd0},
            '{ROW_REG, REG_SPARE_HI, 16'h0123,  1'b0, 7'd0},
            '{ROW_LUX, REG_MODE,     16'd0,     1'b0, 7'd0},
            '{ROW_REG, REG_LUX_LO,   16'd0,     1'b0, 7'd0},
            '{ROW_REG, REG_LUX_HI,   16'hFFFF,  1'b0, 7'd0},
            '{ROW_LUX, REG_MODE,     16'hFFFF,  1'b0, 7'd0},
            '{ROW_LUX, REG_MODE,     16'h7FFF,  1'b0, 7'd0},
            '{ROW_REG, REG_LUX_LO,   16'hFFFE,  1'b0, 7'd0},
            '{ROW_LUX, REG_MODE,     16'hFFFE,  1'b0, 7'd0},
            '{ROW_LUX, REG_MODE,     16'hFFFF,  1'b0, 7'd0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            else
            begin
                send_lux(dir_rows[i].data, dir_rows[i].has_lit, dir_rows[i].lit_pct);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_on = (ph < NUM_PHASES - 2);

            t16    = 16'($urandom());
            t16[0] = ($urandom_range(0, 2) == 0);
            write_reg(REG_MODE, t16);

            case ($urandom_range(0, 5))
                0:       t7 = '0;
                1:       t7 = FULL_PERCENT;
                2:       t7 = '1;
                default: t7 = PCT_W'($urandom_range(0, 100));
            endcase
            t16 = 16'($urandom());
            t16[PCT_W-1:0] = t7;
            write_reg(REG_TARGET, t16);

            case ($urandom_range(0, 6))
                0:
                begin
                    lo_v = '0;
                    hi_v = '1;
                end
                1:
                begin
                    lo_v = 16'($urandom());
                    hi_v = 16'($urandom_range(0, lo_v));
                end
                2:
                begin
                    lo_v = 16'($urandom_range(0, 65000));
                    hi_v = lo_v + 16'($urandom_range(1, 40));
                end
                3:
                begin
                    lo_v = LUX_LO_RESET;
                    hi_v = LUX_HI_RESET;
                end
                default:
                begin
                    lo_v = 16'($urandom());
                    hi_v = 16'($urandom());
                    if (lo_v > hi_v)
                    begin
                        lo_s = lo_v;
                        lo_v = hi_v;
                        hi_v = lo_s;
                    end
                end
            endcase
            write_reg(REG_LUX_LO, lo_v);
            write_reg(REG_LUX_HI, hi_v);

            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                          16'($urandom()));
            end

            if (ph == HOLD_PHASE)
            begin
                hold_req++;
            end

            lo_s = (pred_lo < pred_hi) ? pred_lo : pred_hi;
            hi_s = (pred_lo < pred_hi) ? pred_hi : pred_lo;

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ((ph == PAUSE_PHASE && k == PHASE_ITEMS / 2) ||
                    $urandom_range(0, 59) == 0)
                begin
                    drain_results();
                end
                case ($urandom_range(0, 9))
                    0:       lux_v = '0;
                    1:       lux_v = '1;
                    2:       lux_v = pred_lo;
                    3:       lux_v = pred_hi;
                    4:       lux_v = 16'($urandom_range(0, lo_s));
                    5:       lux_v = 16'($urandom_range(hi_s, 16'hFFFF));
                    6, 7:    lux_v = 16'($urandom());
                    default: lux_v = 16'($urandom_range(lo_s, hi_s));
                endcase
                send_lux(lux_v);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d lux items and %0d register writes over %0d random settings.",
                 items_sent, regs_written, NUM_PHASES);
        $display("Checked %0d brightness results with %0d errors.", results_checked, err_cnt);
        if (err_cnt == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* ambient_brightness_fader_unit.f */
hdl/abf_pkg.sv
hdl/abf_if.sv
hdl/abf_cfg_regs.sv
hdl/abf_div.sv
hdl/ambient_brightness_fader_unit.sv
dv/tb_top.sv
